// File: design/bis_pkg.sv
package bis_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_SRC_W  = 512;
  localparam int MAX_SRC_H  = 512;
  localparam int XW         = $clog2(MAX_SRC_W);
  localparam int YW         = $clog2(MAX_SRC_H);
  localparam int SW_W       = 10;
  localparam int OW_W       = 13;
  localparam int CFG_W      = 13;
  localparam int COORD_W    = 12;
  localparam int STEP_W     = XW + FRAC_BITS;
  localparam int POS_W      = STEP_W + COORD_W;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int WT_W       = FRAC_BITS + 1;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 48;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_OUT_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_OUT_HEIGHT = 2'd3;

  typedef struct packed {
    logic              rd_en;
    logic [XW-1:0]     xl;
    logic [XW-1:0]     xh;
    logic [YW-1:0]     yl;
    logic [YW-1:0]     yh;
    logic              wr_en;
    logic [XW-1:0]     wr_x;
    logic [YW-1:0]     wr_y;
    logic [PIX_W-1:0]  wr_data;
  } fs_req_t;

  typedef struct packed {
    logic [COORD_W-1:0]   col;
    logic [COORD_W-1:0]   row;
    logic [FRAC_BITS-1:0] wx;
    logic [FRAC_BITS-1:0] wy;
  } blend_info_t;

endpackage

// File: design/bis_divider.sv
module bis_divider (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic [bis_pkg::STEP_W-bis_pkg::FRAC_BITS-1:0] s_m1_i,
  input  logic [bis_pkg::OW_W-1:0]                  out_size_i,
  output logic                                      busy_o,
  output logic [bis_pkg::STEP_W-1:0]                step_o
);
  import bis_pkg::*;

  localparam int CNT_W = $clog2(STEP_W + 1);

  logic [STEP_W-1:0] num_q, quo_q, step_q;
  logic [OW_W-1:0]   rem_q, den_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic [OW_W:0]     rem_sh;
  logic              ge;
  logic [OW_W:0]     rem_nx;

  always_comb begin
    rem_sh = {rem_q, num_q[STEP_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      step_q <= '0;
    end else if (start_i) begin
      cnt_q <= '0;
      if (out_size_i <= OW_W'(1)) begin
        busy_q <= 1'b0;
        step_q <= '0;
      end else begin
        busy_q <= 1'b1;
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(STEP_W - 1)) begin
        busy_q <= 1'b0;
        step_q <= {quo_q[STEP_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {s_m1_i, {FRAC_BITS{1'b0}}};
      den_q <= out_size_i - OW_W'(1);
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[STEP_W-2:0], 1'b0};
      quo_q <= {quo_q[STEP_W-2:0], ge};
      rem_q <= rem_nx[OW_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign step_o = step_q;

endmodule

// File: design/bis_frame_store.sv
module bis_frame_store (
  input  logic                        clk_i,
  input  bis_pkg::fs_req_t            req_i,
  output logic [bis_pkg::PIX_W-1:0]   pa_o,
  output logic [bis_pkg::PIX_W-1:0]   pb_o,
  output logic [bis_pkg::PIX_W-1:0]   pc_o,
  output logic [bis_pkg::PIX_W-1:0]   pd_o
);
  import bis_pkg::*;

  localparam int BA_W = (XW - 1) + (YW - 1);

  logic [PIX_W-1:0] rd_q [4];
  logic             xl0_q, xh0_q, yl0_q, yh0_q;

  for (genvar gb = 0; gb < 4; gb++) begin : g_bank
    localparam logic BX = 1'(gb % 2);
    localparam logic BY = 1'(gb / 2);

    logic [PIX_W-1:0] mem [2**BA_W];
    logic [XW-1:0]    rcol;
    logic [YW-1:0]    rrow;
    logic [BA_W-1:0]  raddr;
    logic [BA_W-1:0]  waddr;
    logic             we;

    always_comb begin
      rcol  = (req_i.xl[0] == BX) ? req_i.xl : req_i.xh;
      rrow  = (req_i.yl[0] == BY) ? req_i.yl : req_i.yh;
      raddr = {rrow[YW-1:1], rcol[XW-1:1]};
      waddr = {req_i.wr_y[YW-1:1], req_i.wr_x[XW-1:1]};
      we    = req_i.wr_en && (req_i.wr_x[0] == BX) && (req_i.wr_y[0] == BY);
    end

    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[waddr] <= req_i.wr_data;
      end
      if (req_i.rd_en) begin
        rd_q[gb] <= mem[raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      xl0_q <= req_i.xl[0];
      xh0_q <= req_i.xh[0];
      yl0_q <= req_i.yl[0];
      yh0_q <= req_i.yh[0];
    end
  end

  assign pa_o = rd_q[{yl0_q, xl0_q}];
  assign pb_o = rd_q[{yl0_q, xh0_q}];
  assign pc_o = rd_q[{yh0_q, xl0_q}];
  assign pd_o = rd_q[{yh0_q, xh0_q}];

endmodule

// File: design/bis_blend.sv
module bis_blend (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  bis_pkg::blend_info_t             info_i,
  input  logic [bis_pkg::PIX_W-1:0]        pa_i,
  input  logic [bis_pkg::PIX_W-1:0]        pb_i,
  input  logic [bis_pkg::PIX_W-1:0]        pc_i,
  input  logic [bis_pkg::PIX_W-1:0]        pd_i,
  output logic                             valid_o,
  output logic [bis_pkg::OUT_DATA_W-1:0]   data_o
);
  import bis_pkg::*;

  localparam int T_W = CH_W + FRAC_BITS;
  localparam int P_W = T_W + FRAC_BITS;

  logic                 v5_q, v6_q, v7_q;
  blend_info_t          info5_q, info6_q;
  logic [T_W-1:0]       t_q [3];
  logic [T_W-1:0]       u_q [3];
  logic [P_W-1:0]       pt_q [3];
  logic [P_W-1:0]       pu_q [3];
  logic [CH_W-1:0]      res_q [3];
  logic [COORD_W-1:0]   col_q, row_q;

  logic [WT_W-1:0]      wx_n, wx_p, wy_n, wy_p;
  logic [T_W-1:0]       t_d [3];
  logic [T_W-1:0]       u_d [3];
  logic [P_W:0]         sum [3];
  logic [CH_W-1:0]      res_d [3];

  always_comb begin
    wx_p = {1'b0, info_i.wx};
    wx_n = WT_W'(1 << FRAC_BITS) - wx_p;
    wy_p = {1'b0, info5_q.wy};
    wy_n = WT_W'(1 << FRAC_BITS) - wy_p;
    for (int ch = 0; ch < 3; ch++) begin
      t_d[ch] = T_W'(pa_i[ch*CH_W +: CH_W]) * T_W'(wx_n)
              + T_W'(pb_i[ch*CH_W +: CH_W]) * T_W'(wx_p);
      u_d[ch] = T_W'(pc_i[ch*CH_W +: CH_W]) * T_W'(wx_n)
              + T_W'(pd_i[ch*CH_W +: CH_W]) * T_W'(wx_p);
      sum[ch] = {1'b0, pt_q[ch]} + {1'b0, pu_q[ch]};
      res_d[ch] = (sum[ch][P_W:2*FRAC_BITS] > (P_W+1-2*FRAC_BITS)'(255)) ?
                  CH_W'(255) : sum[ch][2*FRAC_BITS +: CH_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= valid_i;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      info5_q <= info_i;
      info6_q <= info5_q;
      col_q   <= info6_q.col;
      row_q   <= info6_q.row;
      for (int ch = 0; ch < 3; ch++) begin
        t_q[ch]   <= t_d[ch];
        u_q[ch]   <= u_d[ch];
        pt_q[ch]  <= P_W'(t_q[ch]) * P_W'(wy_n);
        pu_q[ch]  <= P_W'(u_q[ch]) * P_W'(wy_p);
        res_q[ch] <= res_d[ch];
      end
    end
  end

  assign valid_o = v7_q;
  assign data_o  = {res_q[0], res_q[1], res_q[2], row_q, col_q};

endmodule

// File: design/bilinear_image_scaler_unit.sv
// Bilinear RGB scaler with corner-aligned sampling over a banked frame store.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// After reset and after each config write, input is held off while the
// 25-step serial divider recomputes the column/row steps.
// Reset sets all sizes to 512; frame store contents are undefined until written.
module bilinear_image_scaler_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // src_x, src_y, in_red, in_green, in_blue, out_col, out_row, zero pad
  input  logic [bis_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // operation
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // res_col, res_row, res_red, res_green, res_blue
  output logic [bis_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [bis_pkg::CFG_W-1:0]          cfg_data_i
);
  import bis_pkg::*;

  logic [SW_W-1:0] src_w_q, src_h_q;
  logic [OW_W-1:0] out_w_q, out_h_q;
  logic            start_q;

  logic [SW_W-1:0] sw, sh;
  logic [XW-1:0]   sw_m1;
  logic [YW-1:0]   sh_m1;
  logic [STEP_W-1:0] col_step, row_step;
  logic            col_busy, row_busy, busy;
  logic            advance, accept;

  logic                 v1_q, op1_q;
  logic [XW-1:0]        x1_q;
  logic [YW-1:0]        y1_q;
  logic [PIX_W-1:0]     rgb1_q;
  logic [COORD_W-1:0]   col1_q, row1_q;

  logic                 v2_q, op2_q;
  logic [XW-1:0]        x2_q;
  logic [YW-1:0]        y2_q;
  logic [PIX_W-1:0]     rgb2_q;
  logic [COORD_W-1:0]   col2_q, row2_q;
  logic [POS_W-1:0]     px2_q, py2_q;

  logic                 v3_q, op3_q;
  logic [XW-1:0]        x3_q;
  logic [YW-1:0]        y3_q;
  logic [PIX_W-1:0]     rgb3_q;
  logic [XW-1:0]        xl3_q, xh3_q;
  logic [YW-1:0]        yl3_q, yh3_q;
  blend_info_t          info3_q;

  logic                 v4_q;
  blend_info_t          info4_q;

  logic [STEP_W-1:0]    xlim, ylim, pxs, pys;
  logic [XW-1:0]        xl_d, xh_d;
  logic [YW-1:0]        yl_d, yh_d;
  logic [SW_W-1:0]      xinc, yinc;

  fs_req_t              fs_req;
  logic [PIX_W-1:0]     pa, pb, pc, pd;

  always_comb begin
    if (src_w_q == '0) begin
      sw = SW_W'(1);
    end else if (src_w_q > SW_W'(MAX_SRC_W)) begin
      sw = SW_W'(MAX_SRC_W);
    end else begin
      sw = src_w_q;
    end
    if (src_h_q == '0) begin
      sh = SW_W'(1);
    end else if (src_h_q > SW_W'(MAX_SRC_H)) begin
      sh = SW_W'(MAX_SRC_H);
    end else begin
      sh = src_h_q;
    end
    sw_m1 = XW'(sw - SW_W'(1));
    sh_m1 = YW'(sh - SW_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SW_W'(512);
      src_h_q <= SW_W'(512);
      out_w_q <= OW_W'(512);
      out_h_q <= OW_W'(512);
      start_q <= 1'b1;
    end else begin
      start_q <= cfg_we_i;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SRC_WIDTH:  src_w_q <= cfg_data_i[SW_W-1:0];
          CFG_SRC_HEIGHT: src_h_q <= cfg_data_i[SW_W-1:0];
          CFG_OUT_WIDTH:  out_w_q <= cfg_data_i[OW_W-1:0];
          CFG_OUT_HEIGHT: out_h_q <= cfg_data_i[OW_W-1:0];
          default: ;
        endcase
      end
    end
  end

  bis_divider u_col_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .s_m1_i     (sw_m1),
    .out_size_i (out_w_q),
    .busy_o     (col_busy),
    .step_o     (col_step)
  );

  bis_divider u_row_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .s_m1_i     (sh_m1),
    .out_size_i (out_h_q),
    .busy_o     (row_busy),
    .step_o     (row_step)
  );

  assign busy          = start_q | col_busy | row_busy;
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance && !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    xlim = {sw_m1, {FRAC_BITS{1'b0}}};
    ylim = {sh_m1, {FRAC_BITS{1'b0}}};
    pxs  = (px2_q > POS_W'(xlim)) ? xlim : px2_q[STEP_W-1:0];
    pys  = (py2_q > POS_W'(ylim)) ? ylim : py2_q[STEP_W-1:0];
    xl_d = pxs[STEP_W-1:FRAC_BITS];
    yl_d = pys[STEP_W-1:FRAC_BITS];
    xinc = {1'b0, xl_d} + SW_W'(1);
    yinc = {1'b0, yl_d} + SW_W'(1);
    xh_d = (xinc < sw) ? xinc[XW-1:0] : sw_m1;
    yh_d = (yinc < sh) ? yinc[YW-1:0] : sh_m1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (advance) begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q && (op3_q == OP_COMPUTE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      op1_q  <= s_axis_tuser;
      x1_q   <= s_axis_tdata[8:0];
      y1_q   <= s_axis_tdata[17:9];
      rgb1_q <= {s_axis_tdata[25:18], s_axis_tdata[33:26], s_axis_tdata[41:34]};
      col1_q <= s_axis_tdata[53:42];
      row1_q <= s_axis_tdata[65:54];

      op2_q  <= op1_q;
      x2_q   <= x1_q;
      y2_q   <= y1_q;
      rgb2_q <= rgb1_q;
      col2_q <= col1_q;
      row2_q <= row1_q;
      px2_q  <= POS_W'(col_step) * POS_W'(col1_q);
      py2_q  <= POS_W'(row_step) * POS_W'(row1_q);

      op3_q        <= op2_q;
      x3_q         <= x2_q;
      y3_q         <= y2_q;
      rgb3_q       <= rgb2_q;
      xl3_q        <= xl_d;
      xh3_q        <= xh_d;
      yl3_q        <= yl_d;
      yh3_q        <= yh_d;
      info3_q.col  <= col2_q;
      info3_q.row  <= row2_q;
      info3_q.wx   <= pxs[FRAC_BITS-1:0];
      info3_q.wy   <= pys[FRAC_BITS-1:0];

      info4_q <= info3_q;
    end
  end

  always_comb begin
    fs_req.rd_en   = advance && v3_q && (op3_q == OP_COMPUTE);
    fs_req.xl      = xl3_q;
    fs_req.xh      = xh3_q;
    fs_req.yl      = yl3_q;
    fs_req.yh      = yh3_q;
    fs_req.wr_en   = advance && v3_q && (op3_q == OP_WRITE);
    fs_req.wr_x    = x3_q;
    fs_req.wr_y    = y3_q;
    fs_req.wr_data = rgb3_q;
  end

  bis_frame_store u_store (
    .clk_i (clk_i),
    .req_i (fs_req),
    .pa_o  (pa),
    .pb_o  (pb),
    .pc_o  (pc),
    .pd_o  (pd)
  );

  bis_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (v4_q),
    .info_i  (info4_q),
    .pa_i    (pa),
    .pb_i    (pb),
    .pc_i    (pc),
    .pd_i    (pd),
    .valid_o (m_axis_tvalid),
    .data_o  (m_axis_tdata)
  );

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !start_q && !col_busy && !row_busy)
    else $error("input ready while steps are being computed");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q)
    else $error("accepted transfer missing from first stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(v1_q) && $stable(v2_q) && $stable(v3_q))
    else $error("pipeline moved during output stall");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bis_pkg::*;

  typedef struct packed {
    logic              op;
    logic [8:0]        x;
    logic [8:0]        y;
    logic [7:0]        r;
    logic [7:0]        g;
    logic [7:0]        b;
    logic [11:0]       col;
    logic [11:0]       row;
  } scaler_item_t;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
  } pixel_res_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i;
  logic [1:0]            cfg_idx_i;
  logic [CFG_W-1:0]      cfg_data_i;

  bilinear_image_scaler_unit u_top (.*);

  scaler_item_t pending_q[$];
  pixel_res_t   expected_pix_q[$];
  logic [23:0]  frame_mem[int];
  int unsigned  sw_cfg, sh_cfg, ow_cfg, oh_cfg;
  longint unsigned col_step, row_step;
  int errors;
  int send_gap, recv_gap;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("[bilinear_image_scaler_unit] ERROR");
    $finish;
  end

  function automatic int unsigned eff_src(int unsigned v);
    if (v < 1) return 1;
    if (v > 512) return 512;
    return v;
  endfunction

  function automatic longint unsigned step_of(int unsigned s, int unsigned o);
    if (o <= 1) return 0;
    return (longint'(s - 1) << FRAC_BITS) / longint'(o - 1);
  endfunction

  function automatic longint unsigned clamp_pos(longint unsigned st, int unsigned c,
                                                int unsigned s);
    longint unsigned lim, p;
    lim = longint'(s - 1) << FRAC_BITS;
    p = st * c;
    return (p > lim) ? lim : p;
  endfunction

  function automatic logic [7:0] mix(longint unsigned a, longint unsigned b,
                                     longint unsigned c, longint unsigned d,
                                     longint unsigned wx, longint unsigned wy);
    longint unsigned one, t, u, v;
    one = 64'd1 << FRAC_BITS;
    t = a * (one - wx) + b * wx;
    u = c * (one - wx) + d * wx;
    v = (t * (one - wy) + u * wy) >> (2 * FRAC_BITS);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [23:0] fetch(int unsigned x, int unsigned y);
    int k;
    k = y * 512 + x;
    return frame_mem.exists(k) ? frame_mem[k] : 24'd0;
  endfunction

  function automatic void predict_pixel(scaler_item_t it);
    int unsigned sw, sh, xl, yl, xh, yh;
    longint unsigned px, py, wx, wy;
    logic [23:0] pa, pb, pc, pd;
    pixel_res_t res;
    if (it.op == OP_WRITE) begin
      frame_mem[it.y * 512 + it.x] = {it.r, it.g, it.b};
      return;
    end
    sw = eff_src(sw_cfg);
    sh = eff_src(sh_cfg);
    px = clamp_pos(col_step, it.col, sw);
    py = clamp_pos(row_step, it.row, sh);
    xl = 32'(px >> FRAC_BITS);
    yl = 32'(py >> FRAC_BITS);
    wx = px & 64'hFFFF;
    wy = py & 64'hFFFF;
    xh = (xl + 1 < sw) ? xl + 1 : sw - 1;
    yh = (yl + 1 < sh) ? yl + 1 : sh - 1;
    pa = fetch(xl, yl);
    pb = fetch(xh, yl);
    pc = fetch(xl, yh);
    pd = fetch(xh, yh);
    res.col = it.col;
    res.row = it.row;
    res.r = mix(pa[23:16], pb[23:16], pc[23:16], pd[23:16], wx, wy);
    res.g = mix(pa[15:8], pb[15:8], pc[15:8], pd[15:8], wx, wy);
    res.b = mix(pa[7:0], pb[7:0], pc[7:0], pd[7:0], wx, wy);
    expected_pix_q = {expected_pix_q, res};
  endfunction

  function automatic pixel_res_t unpack_res(logic [OUT_DATA_W-1:0] d);
    pixel_res_t p;
    p.col = d[11:0];
    p.row = d[23:12];
    p.r   = d[31:24];
    p.g   = d[39:32];
    p.b   = d[47:40];
    return p;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_pixel(pending_q.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
      end else if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_q[0].op;
        s_axis_tdata  <= {6'd0, pending_q[0].row, pending_q[0].col, pending_q[0].b,
                          pending_q[0].g, pending_q[0].r, pending_q[0].y, pending_q[0].x};
        send_gap <= ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 8)) : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_res_t got, exp_pix;
    int gap_draw;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = unpack_res(m_axis_tdata);
        if (expected_pix_q.size() == 0) begin
          $error("unexpected result col=%0d row=%0d", got.col, got.row);
          errors++;
        end else begin
          exp_pix = expected_pix_q.pop_front();
          if (got.col !== exp_pix.col) begin
            $error("res_col exp %0d got %0d", exp_pix.col, got.col); errors++;
          end
          if (got.row !== exp_pix.row) begin
            $error("res_row exp %0d got %0d", exp_pix.row, got.row); errors++;
          end
          if (got.r !== exp_pix.r) begin
            $error("res_red exp %0d got %0d", exp_pix.r, got.r); errors++;
          end
          if (got.g !== exp_pix.g) begin
            $error("res_green exp %0d got %0d", exp_pix.g, got.g); errors++;
          end
          if (got.b !== exp_pix.b) begin
            $error("res_blue exp %0d got %0d", exp_pix.b, got.b); errors++;
          end
        end
        gap_draw = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 8)) : 0;
        if (gap_draw > 0) begin
          m_axis_tready <= 1'b0;
          recv_gap <= gap_draw - 1;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_write(int x, int y, logic [23:0] rgb);
    scaler_item_t it;
    it = '0;
    it.op = OP_WRITE;
    it.x = 9'(x);
    it.y = 9'(y);
    {it.r, it.g, it.b} = rgb;
    it.col = 12'($urandom);
    it.row = 12'($urandom);
    pending_q = {pending_q, it};
  endtask

  task automatic push_compute(int c, int r);
    scaler_item_t it;
    it = '0;
    it.op = OP_COMPUTE;
    it.col = 12'(c);
    it.row = 12'(r);
    it.x = 9'($urandom);
    it.y = 9'($urandom);
    it.r = 8'($urandom);
    it.g = 8'($urandom);
    it.b = 8'($urandom);
    pending_q = {pending_q, it};
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !s_axis_tvalid);
    wait (expected_pix_q.size() == 0);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_W'(val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_SRC_WIDTH:  sw_cfg = val & 10'h3FF;
      CFG_SRC_HEIGHT: sh_cfg = val & 10'h3FF;
      CFG_OUT_WIDTH:  ow_cfg = val & 13'h1FFF;
      default:        oh_cfg = val & 13'h1FFF;
    endcase
    col_step = step_of(eff_src(sw_cfg), ow_cfg);
    row_step = step_of(eff_src(sh_cfg), oh_cfg);
  endtask

  // fill the whole effective source area, then random computes mixed with occasional writes
  task automatic run_phase(int sw, int sh, int ow, int oh, int n_comp);
    int esw, esh;
    write_reg(CFG_SRC_WIDTH, sw);
    write_reg(CFG_SRC_HEIGHT, sh);
    write_reg(CFG_OUT_WIDTH, ow);
    write_reg(CFG_OUT_HEIGHT, oh);
    esw = eff_src(sw);
    esh = eff_src(sh);
    for (int y = 0; y < esh; y++)
      for (int x = 0; x < esw; x++)
        push_write(x, y, $urandom);
    for (int i = 0; i < n_comp; i++) begin
      if ($urandom_range(0, 9) == 0)
        push_write($urandom_range(0, esw - 1), $urandom_range(0, esh - 1), $urandom);
      if ($urandom_range(0, 5) == 0)
        push_compute($urandom_range(0, 4095), $urandom_range(0, 4095));
      else
        push_compute($urandom_range(0, ow), $urandom_range(0, oh));
    end
    drain();
  endtask

  initial begin
    errors = 0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    sw_cfg = 512; sh_cfg = 512; ow_cfg = 512; oh_cfg = 512;
    col_step = step_of(512, 512);
    row_step = step_of(512, 512);
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (40) @(posedge clk_i);

    // directed: small frame, extremes, corners, beyond edge, colors 0/255
    write_reg(CFG_SRC_WIDTH, 2);
    write_reg(CFG_SRC_HEIGHT, 2);
    write_reg(CFG_OUT_WIDTH, 3);
    write_reg(CFG_OUT_HEIGHT, 3);
    push_write(0, 0, 24'h000000);
    push_write(1, 0, 24'hFFFFFF);
    push_write(0, 1, 24'hFF00FF);
    push_write(1, 1, 24'h00FF00);
    push_write(511, 511, 24'hFFFFFF);
    push_write(511, 0, 24'h123456);
    push_write(0, 511, 24'hABCDEF);
    push_write(256, 256, 24'h5AA55A);
    push_compute(0, 0);
    push_compute(1, 1);
    push_compute(2, 2);
    push_compute(1, 0);
    push_compute(4095, 4095);
    push_compute(3, 4095);
    push_compute(2048, 1);
    drain();
    // pause until all results are in, then continue
    run_phase(0, 0, 0, 0, 10);
    run_phase(5, 3, 1, 9, 60);
    run_phase(7, 6, 4096, 4096, 100);
    run_phase(8, 6, 4, 40, 80);
    run_phase(1023, 1, 8191, 3, 60);
    run_phase(9, 5, 2, 2, 40);
    drain();

    if (errors == 0)
      $display("[bilinear_image_scaler_unit] OK");
    else
      $display("[bilinear_image_scaler_unit] ERROR");
    $finish;
  end

endmodule
